// ===== sv/crdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// crdcm_pkg
// Shared types and constants for the camera row decimator with color map.
// ----------------------------------------------------------------------------
package crdcm_pkg;

    localparam int CMD_W      = 3;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int ROW_POS_W  = 15;
    localparam int ROW_CNT_W  = 16;
    localparam int PIX_CODE_W = 10;   // low bits of a pixel word that address the map

    localparam int ROW_WORDS_DEF   = 640;
    localparam int OUT_PIXELS_DEF  = 320;
    localparam int MAP_ENTRIES_DEF = 1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL       = 3'd0,
        CMD_ROW_DONE    = 3'd1,
        CMD_FRAME_START = 3'd2,
        CMD_REQUEST     = 3'd3,
        CMD_MAP_WRITE   = 3'd4,
        CMD_READ        = 3'd5
    } t_cmd;

endpackage

// ===== sv/camera_row_decimate_color_map.sv =====
// ----------------------------------------------------------------------------
// camera_row_decimate_color_map
// Halves and mirrors odd camera rows, maps pixel codes to display colors and
// double-buffers the result row for readout.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the map / bank RAM read, then the output
//   register. Throughput: one item per cycle while the output is not stalled,
//   through the registered read ports of the color map and row bank RAMs.
// Reset: control state clears at once; then both row banks are swept to zero,
//   one position per cycle over all OUT_PIXELS positions, with no item accepted.
//   The color map is not cleared.
// ----------------------------------------------------------------------------
module camera_row_decimate_color_map
    import crdcm_pkg::*;
#(
    parameter int ROW_WORDS   = ROW_WORDS_DEF,
    parameter int OUT_PIXELS  = OUT_PIXELS_DEF,
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [INDEX_W-1:0]   i_index,
    input  logic [VALUE_W-1:0]   i_value,
    // result item channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [COLOR_W-1:0]   o_color,
    output logic [ROW_POS_W-1:0] o_row_pos,
    output logic                 o_ready_res
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int ROW_W  = $clog2(ROW_WORDS + 1);
    localparam int OPW    = $clog2(OUT_PIXELS + 1);
    localparam int CW0    = (ROW_W > INDEX_W) ? ROW_W : INDEX_W;
    localparam int CW     = (CW0 > OPW) ? CW0 : OPW;          // column math width
    localparam int PA     = (OUT_PIXELS > 1) ? $clog2(OUT_PIXELS) : 1;
    localparam int MA     = $clog2(MAP_ENTRIES);
    localparam int MAPW   = $clog2(MAP_ENTRIES + 1);
    localparam int MW     = (MAPW > INDEX_W) ? MAPW : INDEX_W;  // map address compare
    localparam longint CODE_MAX = (longint'(1) << PIX_CODE_W) - 1;

    // Pixel code reduced into the map range: conditional subtract of
    // shifted copies of the map size, one per code bit.
    function automatic logic [MA-1:0] map_code(input logic [PIX_CODE_W-1:0] raw);
        logic [PIX_CODE_W-1:0] v;
        v = raw;
        for (int k = PIX_CODE_W - 1; k >= 0; k--) begin
            if ((longint'(MAP_ENTRIES) << k) <= CODE_MAX) begin
                if (v >= PIX_CODE_W'(longint'(MAP_ENTRIES) << k)) begin
                    v = v - PIX_CODE_W'(longint'(MAP_ENTRIES) << k);
                end
            end
        end
        return MA'(v);
    endfunction

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [ROW_CNT_W-1:0] r_row_counter, n_row_counter;
    logic                 r_req_pending, n_req_pending;
    logic [ROW_POS_W-1:0] r_captured_row, n_captured_row;
    logic                 r_disp_bank, n_disp_bank;

    // Bank clearing sweep after reset
    logic                 r_clr_busy;
    logic [PA-1:0]        r_clr_addr;

    // Stage 1: item waiting on RAM read data
    logic                 r_s1_valid;
    logic                 r_s1_pix;        // pixel that writes the staging bank
    logic                 r_s1_rd;         // read within the row
    logic                 r_s1_bank;       // bank written (pixel) or read (read)
    logic [PA-1:0]        r_s1_pos;
    logic [ROW_POS_W-1:0] r_s1_row_pos;
    logic                 r_s1_ready_res;

    // Output register
    logic                 r_out_valid;
    logic [COLOR_W-1:0]   r_out_color;
    logic [ROW_POS_W-1:0] r_out_row_pos;
    logic                 r_out_ready_res;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic s1_move, accept;
    t_cmd cmd;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_move);
    assign accept     = i_in_valid && o_in_ready;
    assign cmd        = t_cmd'(i_cmd);

    // ------------------------------------------------------------------
    // Column decode: keep every second column counted from the right end
    // ------------------------------------------------------------------
    logic [CW-1:0] col_ext, col_off, half_off;
    logic          pix_keep;
    logic [PA-1:0] pix_pos;

    assign col_ext  = CW'(i_index);
    assign col_off  = CW'(ROW_WORDS - 1) - col_ext;
    assign half_off = col_off >> 1;
    assign pix_keep = (col_ext < CW'(ROW_WORDS)) && !col_off[0]
                      && (half_off < CW'(OUT_PIXELS));
    assign pix_pos  = half_off[PA-1:0];

    logic rd_in_row;
    assign rd_in_row = col_ext < CW'(OUT_PIXELS);

    logic map_wr_ok;
    assign map_wr_ok = MW'(i_index) < MW'(MAP_ENTRIES);

    // ------------------------------------------------------------------
    // Control state next values
    // ------------------------------------------------------------------
    always_comb begin
        n_row_counter  = r_row_counter;
        n_req_pending  = r_req_pending;
        n_captured_row = r_captured_row;
        n_disp_bank    = r_disp_bank;
        case (cmd)
            CMD_ROW_DONE: begin
                // swap only on an odd row with a request waiting
                if (r_req_pending && r_row_counter[0]) begin
                    n_disp_bank    = !r_disp_bank;
                    n_captured_row = r_row_counter[ROW_CNT_W-1:1];
                    n_req_pending  = 1'b0;
                end
                n_row_counter = r_row_counter + ROW_CNT_W'(1);
            end
            CMD_FRAME_START: n_row_counter = '0;
            CMD_REQUEST:     n_req_pending = 1'b1;
            default:         ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_counter  <= '0;
            r_req_pending  <= 1'b0;
            r_captured_row <= '0;
            r_disp_bank    <= 1'b0;
        end else if (accept) begin
            r_row_counter  <= n_row_counter;
            r_req_pending  <= n_req_pending;
            r_captured_row <= n_captured_row;
            r_disp_bank    <= n_disp_bank;
        end
    end

    // ------------------------------------------------------------------
    // Clearing sweep over both banks
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == PA'(OUT_PIXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + PA'(1);
        end
    end

    // ------------------------------------------------------------------
    // Color map RAM: written by map write items, read by pixel items
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] map_rdata;

    crdcm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAP_ENTRIES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (cmd == CMD_MAP_WRITE) && map_wr_ok),
        .i_waddr (MA'(i_index)),
        .i_wdata (i_value),
        .i_re    (accept && (cmd == CMD_PIXEL)),
        .i_raddr (map_code(i_value[PIX_CODE_W-1:0])),
        .o_rdata (map_rdata)
    );

    // ------------------------------------------------------------------
    // Row banks: one RAM per bank. Pixels write the staging bank when they
    // leave stage 1; reads fetch from the display bank at accept.
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] bank_rdata [2];
    logic               pix_wr;
    logic               bank_re;

    assign pix_wr  = s1_move && r_s1_pix;
    assign bank_re = accept && (cmd == CMD_READ) && rd_in_row;

    function automatic logic [PA-1:0] pix_pos_or_rd(input logic [INDEX_W-1:0] idx);
        return PA'(idx);
    endfunction

    for (genvar b = 0; b < 2; b++) begin : g_bank
        crdcm_ram #(
            .WIDTH (COLOR_W),
            .DEPTH (OUT_PIXELS)
        ) u_bank_ram (
            .i_clk   (i_clk),
            .i_we    (r_clr_busy || (pix_wr && (r_s1_bank == 1'(b)))),
            .i_waddr (r_clr_busy ? r_clr_addr : r_s1_pos),
            .i_wdata (r_clr_busy ? COLOR_W'(0) : map_rdata),
            .i_re    (bank_re && (r_disp_bank == 1'(b))),
            .i_raddr (pix_pos_or_rd(i_index)),
            .o_rdata (bank_rdata[b])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pix <= 1'b0;
        end else if (accept) begin
            r_s1_pix <= (cmd == CMD_PIXEL) && pix_keep;
        end else if (s1_move) begin
            r_s1_pix <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd        <= bank_re;
            r_s1_bank      <= (cmd == CMD_PIXEL) ? !r_disp_bank : r_disp_bank;
            r_s1_pos       <= pix_pos;
            r_s1_row_pos   <= n_captured_row;
            r_s1_ready_res <= !n_req_pending;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_color     <= r_s1_rd ? bank_rdata[r_s1_bank] : COLOR_W'(0);
            r_out_row_pos   <= r_s1_row_pos;
            r_out_ready_res <= r_s1_ready_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_color     = r_out_color;
    assign o_row_pos   = r_out_row_pos;
    assign o_ready_res = r_out_ready_res;

endmodule

// ===== sv/crdcm_ram.sv =====
// ----------------------------------------------------------------------------
// crdcm_ram
// Generic single-write, single-read RAM with registered, enabled read port.
// ----------------------------------------------------------------------------
module crdcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
